FILE: rtl/core/zsrs_pkg.sv
// zsrs_pkg: shared constants, state encoding and controller/datapath
// command and status types for the zone set range search block.
// No dependencies.
package zsrs_pkg;

    // Field and bus widths
    localparam int FIELD_W    = 64;
    localparam int IN_DATA_W  = 4 * FIELD_W;
    localparam int OUT_DATA_W = 2 * FIELD_W;

    // Default sizing
    localparam int ZONE_COUNT_DEF = 64;
    localparam int ADDR_BITS_DEF  = 64;

    // zone_shift register
    localparam int              SHIFT_W        = 6;
    localparam logic [SHIFT_W-1:0] ZONE_SHIFT_RST = 6'd20;

    // APB port
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_ZONE_SHIFT = 1'b0;

    // Bits of the stripe index reduced per cycle by the zone modulo unit
    localparam int CHUNK_W = 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_CLIP,
        ST_MOD,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic prep;
        logic clip;
        logic mod_step;
        logic scan_step;
    } dp_cmd_t;

    typedef struct packed {
        logic prep_decided;
        logic mod_done;
        logic scan_finish;
    } dp_sts_t;

endpackage

FILE: rtl/core/zsrs_out.sv
// zsrs_out: result register stage for the m_ stream port.
// Depends on zsrs_pkg.
module zsrs_out (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             push,
    input  logic                             found,
    input  logic [zsrs_pkg::FIELD_W-1:0]     run_base,
    input  logic [zsrs_pkg::FIELD_W-1:0]     run_limit,
    output logic                             free,
    input  logic                             m_tready,
    output logic                             m_tvalid,
    output logic                             m_tuser,   // found
    output logic [zsrs_pkg::OUT_DATA_W-1:0]  m_tdata    // run_base, run_limit
);

    logic                             valid_reg;
    logic                             found_reg;
    logic [zsrs_pkg::OUT_DATA_W-1:0]  data_reg;

    // slot can take a new result when empty or draining this cycle
    assign free = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (push) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            found_reg <= found;
            data_reg  <= {run_limit, run_base};
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = found_reg;
    assign m_tdata  = data_reg;

endmodule

FILE: rtl/core/zsrs_ctrl.sv
// zsrs_ctrl: sequencer for one search request at a time.
// Depends on zsrs_pkg; drives zsrs_dp through dp_cmd_t / dp_sts_t.
module zsrs_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              out_free,
    output logic              out_push,
    input  zsrs_pkg::dp_sts_t sts,
    output zsrs_pkg::dp_cmd_t cmd
);

    zsrs_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= zsrs_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            zsrs_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = zsrs_pkg::ST_PREP;
            end
            zsrs_pkg::ST_PREP: begin
                state_next = sts.prep_decided ? zsrs_pkg::ST_DONE : zsrs_pkg::ST_CLIP;
            end
            zsrs_pkg::ST_CLIP: begin
                state_next = zsrs_pkg::ST_MOD;
            end
            zsrs_pkg::ST_MOD: begin
                if (sts.mod_done) state_next = zsrs_pkg::ST_SCAN;
            end
            zsrs_pkg::ST_SCAN: begin
                if (sts.scan_finish) state_next = zsrs_pkg::ST_DONE;
            end
            zsrs_pkg::ST_DONE: begin
                if (out_free) state_next = zsrs_pkg::ST_IDLE;
            end
            default: begin
                state_next = zsrs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd       = '0;
        s_tready  = 1'b0;
        out_push  = 1'b0;
        case (state_reg)
            zsrs_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            zsrs_pkg::ST_PREP: cmd.prep      = 1'b1;
            zsrs_pkg::ST_CLIP: cmd.clip      = 1'b1;
            zsrs_pkg::ST_MOD:  cmd.mod_step  = 1'b1;
            zsrs_pkg::ST_SCAN: cmd.scan_step = 1'b1;
            zsrs_pkg::ST_DONE: out_push      = out_free;
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: rtl/core/zsrs_dp.sv
// zsrs_dp: search datapath - range checks, zebra clipping, zone modulo
// unit and the stripe-by-stripe scan. Depends on zsrs_pkg.
module zsrs_dp #(
    parameter int ZONE_COUNT = zsrs_pkg::ZONE_COUNT_DEF,
    parameter int ADDR_BITS  = zsrs_pkg::ADDR_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [zsrs_pkg::SHIFT_W-1:0]    zone_shift,
    input  logic                            in_kind,
    input  logic [zsrs_pkg::FIELD_W-1:0]    in_base,
    input  logic [zsrs_pkg::FIELD_W-1:0]    in_limit,
    input  logic [zsrs_pkg::FIELD_W-1:0]    in_zones,
    input  logic [zsrs_pkg::FIELD_W-1:0]    in_size,
    input  zsrs_pkg::dp_cmd_t               cmd,
    output zsrs_pkg::dp_sts_t               sts,
    output logic                            res_found,
    output logic [ADDR_BITS-1:0]            res_base,
    output logic [ADDR_BITS-1:0]            res_limit
);

    localparam int FW     = zsrs_pkg::FIELD_W;
    localparam int AW     = ADDR_BITS;
    localparam int SW     = zsrs_pkg::SHIFT_W;
    localparam int CW     = zsrs_pkg::CHUNK_W;
    localparam int ZW     = $clog2(ZONE_COUNT);
    localparam int NCHUNK = (AW + CW - 1) / CW;
    localparam int PADW   = NCHUNK * CW;
    localparam int CNT_W  = $clog2(NCHUNK);

    localparam logic [AW-1:0]    ZC_A   = AW'(ZONE_COUNT);
    localparam logic [ZW:0]      ZC_R   = (ZW+1)'(ZONE_COUNT);
    localparam logic [ZW-1:0]    ZLAST  = ZW'(ZONE_COUNT - 1);
    localparam logic [SW-1:0]    SMAX   = SW'(AW - 1);
    localparam logic [CNT_W-1:0] CLAST  = CNT_W'(NCHUNK - 1);

    // request and per-request configuration
    logic                   dir_reg;
    logic [AW-1:0]          base_reg, limit_reg;
    logic [ZONE_COUNT-1:0]  zmask_reg;
    logic [FW-1:0]          size_reg;
    logic [SW-1:0]          sshift_reg;
    logic [AW-1:0]          stripe_reg, lowm_reg, zebra_reg;
    logic                   big_reg;
    // working state
    logic [AW-1:0]          edge_reg, pos_reg, anchor_reg;
    logic                   run_reg;
    logic [ZW-1:0]          zone_reg;
    logic [PADW-1:0]        modv_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   found_reg;
    logic [AW-1:0]          rbase_reg, rlimit_reg;

    // config derived, sampled at load
    logic [SW-1:0] sshift_c;
    logic [AW-1:0] stripe_c, zebra_c;
    logic          big_c;

    assign sshift_c = (zone_shift > SMAX) ? SMAX : zone_shift;
    assign stripe_c = AW'(1) << sshift_c;
    assign zebra_c  = ZC_A << sshift_c;
    assign big_c    = ({AW{1'b1}} >> sshift_c) < ZC_A;

    // prep
    logic [AW-1:0] span, au, ad;
    logic          range_ok, all_zones, size_ok;

    assign span      = limit_reg - base_reg;
    assign range_ok  = (base_reg < limit_reg) && (FW'(span) >= size_reg);
    assign all_zones = &zmask_reg;
    assign size_ok   = big_reg || (size_reg < FW'(zebra_reg));
    assign au        = (base_reg + lowm_reg) & ~lowm_reg;
    assign ad        = limit_reg & ~lowm_reg;

    // clip: at most one zone cycle past the first aligned stripe
    logic [AW-1:0] sl, sb, src, idx;
    logic          clip_first, clip_last;

    assign sl         = edge_reg + zebra_reg;
    assign sb         = edge_reg - zebra_reg;
    assign clip_first = !big_reg && (sl > base_reg) && (limit_reg > sl);
    assign clip_last  = !big_reg && (sb < limit_reg) && (base_reg < sb);
    assign src        = dir_reg ? (limit_reg - AW'(1)) : base_reg;
    assign idx        = src >> sshift_reg;

    // zone modulo: CW bits of the stripe index per cycle, MSB first
    logic [ZW:0] rem_c;

    always_comb begin
        rem_c = {1'b0, zone_reg};
        for (int i = 0; i < CW; i++) begin
            rem_c = {rem_c[ZW-1:0], modv_reg[PADW-1-i]};
            if (rem_c >= ZC_R) rem_c = rem_c - ZC_R;
        end
    end

    // scan
    logic [AW-1:0] up_n, up_next, dn_p, dn_next, run_len;
    logic [ZW-1:0] zone_next;
    logic          zone_ok, at_end, len_ok, hit;

    assign zone_ok   = zmask_reg[zone_reg];
    assign up_n      = (pos_reg + stripe_reg) & ~lowm_reg;
    assign up_next   = (up_n >= limit_reg || up_n < pos_reg) ? limit_reg : up_n;
    assign dn_p      = (pos_reg - AW'(1)) & ~lowm_reg;
    assign dn_next   = (dn_p < base_reg) ? base_reg : dn_p;
    assign at_end    = dir_reg ? (pos_reg <= base_reg) : (pos_reg >= limit_reg);
    assign run_len   = dir_reg ? (anchor_reg - pos_reg) : (pos_reg - anchor_reg);
    assign len_ok    = FW'(run_len) >= size_reg;
    assign hit       = run_reg && len_ok;
    assign zone_next = dir_reg ? ((zone_reg == '0) ? ZLAST : zone_reg - ZW'(1))
                               : ((zone_reg == ZLAST) ? '0 : zone_reg + ZW'(1));

    assign sts.prep_decided = !range_ok || all_zones || !size_ok;
    assign sts.mod_done     = (cnt_reg == CLAST);
    assign sts.scan_finish  = at_end || (!zone_ok && hit);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg   <= 1'b0;
            cnt_reg   <= '0;
            found_reg <= 1'b0;
        end else begin
            if (cmd.prep) begin
                found_reg <= range_ok && all_zones;
            end
            if (cmd.clip) begin
                run_reg <= 1'b0;
                cnt_reg <= '0;
            end
            if (cmd.mod_step) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (cmd.scan_step) begin
                if (sts.scan_finish) begin
                    found_reg <= hit;
                end else if (zone_ok && !run_reg) begin
                    run_reg <= 1'b1;
                end else if (!zone_ok && run_reg) begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            dir_reg    <= in_kind;
            base_reg   <= in_base[AW-1:0];
            limit_reg  <= in_limit[AW-1:0];
            zmask_reg  <= in_zones[ZONE_COUNT-1:0];
            size_reg   <= in_size;
            sshift_reg <= sshift_c;
            stripe_reg <= stripe_c;
            lowm_reg   <= stripe_c - AW'(1);
            zebra_reg  <= zebra_c;
            big_reg    <= big_c;
        end
        if (cmd.prep) begin
            edge_reg   <= dir_reg ? ad : au;
            rbase_reg  <= (range_ok && all_zones) ? base_reg : '0;
            rlimit_reg <= (range_ok && all_zones) ? limit_reg : '0;
        end
        if (cmd.clip) begin
            if (!dir_reg && clip_first) limit_reg <= sl;
            if (dir_reg && clip_last)   base_reg  <= sb;
            pos_reg  <= dir_reg ? limit_reg : base_reg;
            modv_reg <= PADW'(idx);
            zone_reg <= '0;
        end
        if (cmd.mod_step) begin
            zone_reg <= rem_c[ZW-1:0];
            modv_reg <= modv_reg << CW;
        end
        if (cmd.scan_step) begin
            if (sts.scan_finish) begin
                rbase_reg  <= hit ? (dir_reg ? pos_reg : anchor_reg) : '0;
                rlimit_reg <= hit ? (dir_reg ? anchor_reg : pos_reg) : '0;
            end else begin
                if (zone_ok && !run_reg) anchor_reg <= pos_reg;
                pos_reg  <= dir_reg ? dn_next : up_next;
                zone_reg <= zone_next;
            end
        end
    end

    assign res_found = found_reg;
    assign res_base  = rbase_reg;
    assign res_limit = rlimit_reg;

endmodule

FILE: rtl/core/zone_set_range_search.sv
// Zone set range search. Each request on the s_ stream names an address
// range [range_base, range_limit), a mask of allowed zones, a minimum run
// size in bytes and a direction (s_tuser: 0 = lowest run, 1 = highest run).
// The address space is cut into stripes of 2^zone_shift bytes; a stripe's
// zone is its stripe index mod ZONE_COUNT. One result comes back per
// request on the m_ stream: m_tuser is found, m_tdata holds the run's base
// and limit (both zero when nothing qualifies). zone_shift lives at APB
// byte address 0, resets to 20, and may only be written while the block
// is idle. A request is checked in the cycle after its acceptance; an
// out-of-range request, a too-large size or an all-ones mask completes
// there. Otherwise a clip step, the zone modulo unit and a stripe scan
// follow; the scan tests one stripe a cycle. Requests are handled one at
// a time; a finished result sits in its own output register, so the next
// request is taken while it waits.
// Depends on zsrs_pkg, zsrs_ctrl, zsrs_dp and zsrs_out.
module zone_set_range_search #(
    parameter int ZONE_COUNT = zsrs_pkg::ZONE_COUNT_DEF,  // 8..64
    parameter int ADDR_BITS  = zsrs_pkg::ADDR_BITS_DEF    // 32..64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // request stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic                              s_tuser,   // kind
    // range_base, range_limit, allowed_zones, min_size
    input  logic [zsrs_pkg::IN_DATA_W-1:0]    s_tdata,
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic                              m_tuser,   // found
    output logic [zsrs_pkg::OUT_DATA_W-1:0]   m_tdata,   // run_base, run_limit
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [zsrs_pkg::PADDR_W-1:0]      paddr,
    input  logic [zsrs_pkg::PDATA_W-1:0]      pwdata,
    output logic [zsrs_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);

    localparam int FW = zsrs_pkg::FIELD_W;
    localparam int PW = zsrs_pkg::PDATA_W;
    localparam int SW = zsrs_pkg::SHIFT_W;

    // ---------------------------------------------------------------
    // APB register: zone_shift. Word index is paddr[2]; low bits ignored.
    // ---------------------------------------------------------------
    logic [SW-1:0] zone_shift_reg;
    logic          reg_sel;
    logic          cfg_wr;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[zsrs_pkg::PADDR_W-1:2] == zsrs_pkg::REG_ZONE_SHIFT);
    assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;
    assign prdata  = reg_sel ? PW'(zone_shift_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zone_shift_reg <= zsrs_pkg::ZONE_SHIFT_RST;
        end else if (cfg_wr) begin
            zone_shift_reg <= pwdata[SW-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Controller / datapath
    // ---------------------------------------------------------------
    zsrs_pkg::dp_cmd_t     cmd;
    zsrs_pkg::dp_sts_t     sts;
    logic                  out_free;
    logic                  out_push;
    logic                  res_found;
    logic [ADDR_BITS-1:0]  res_base;
    logic [ADDR_BITS-1:0]  res_limit;

    zsrs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .out_free (out_free),
        .out_push (out_push),
        .sts      (sts),
        .cmd      (cmd)
    );

    zsrs_dp #(
        .ZONE_COUNT (ZONE_COUNT),
        .ADDR_BITS  (ADDR_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .zone_shift (zone_shift_reg),
        .in_kind    (s_tuser),
        .in_base    (s_tdata[FW-1:0]),
        .in_limit   (s_tdata[2*FW-1:FW]),
        .in_zones   (s_tdata[3*FW-1:2*FW]),
        .in_size    (s_tdata[4*FW-1:3*FW]),
        .cmd        (cmd),
        .sts        (sts),
        .res_found  (res_found),
        .res_base   (res_base),
        .res_limit  (res_limit)
    );

    // ---------------------------------------------------------------
    // Result register; addresses zero-extended to the field width
    // ---------------------------------------------------------------
    zsrs_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (out_push),
        .found     (res_found),
        .run_base  (FW'(res_base)),
        .run_limit (FW'(res_limit)),
        .free      (out_free),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata)
    );

endmodule
